>>> hdl/hcbp_pkg.sv
// Shared constants for the code bit packer.
package hcbp_pkg;

  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int SYMBOLS_DEF      = 256;
  localparam int FIELD_CODE_BITS  = 32;
  localparam int BYTE_BITS        = 8;

  localparam logic [7:0] TRAILER_BASE = 8'd48;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_ENC   = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  typedef logic [2:0] state_t;

  localparam state_t ST_IDLE  = 3'd0;
  localparam state_t ST_LOAD  = 3'd1;
  localparam state_t ST_SHIFT = 3'd2;
  localparam state_t ST_PAD   = 3'd3;
  localparam state_t ST_TRAIL = 3'd4;

endpackage

>>> hdl/hcbp_code_table.sv
// Code table memory with per-entry valid flags and a registered read port.
module hcbp_code_table #(
  parameter int SYMBOLS = hcbp_pkg::SYMBOLS_DEF,
  parameter int CODE_W  = hcbp_pkg::FIELD_CODE_BITS,
  parameter int AW      = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1,
  parameter int LEN_W   = $clog2(CODE_W + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [CODE_W-1:0] wr_bits,
  input  logic [LEN_W-1:0]  wr_len,
  input  logic [AW-1:0]     rd_addr,
  output logic [CODE_W-1:0] rd_bits,
  output logic [LEN_W-1:0]  rd_len
);

  logic [CODE_W-1:0] bits_mem [SYMBOLS];
  logic [LEN_W-1:0]  len_mem  [SYMBOLS];
  logic [SYMBOLS-1:0] vld_r;
  logic [CODE_W-1:0] rd_bits_r;
  logic [LEN_W-1:0]  rd_len_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bits_mem[wr_addr] <= wr_bits;
      len_mem[wr_addr]  <= wr_len;
    end
  end

  always_ff @(posedge clk) begin
    rd_bits_r <= bits_mem[rd_addr];
    rd_len_r  <= len_mem[rd_addr];
    rd_vld_r  <= vld_r[rd_addr];
  end

  assign rd_bits = rd_bits_r;
  assign rd_len  = rd_vld_r ? rd_len_r : '0;

endmodule

>>> hdl/huffman_code_bit_packer.sv
// Code bit packer top level: table load, bit-serial packing, flush and trailer.
// A load item writes its table entry; the packer stays idle. A symbol item
// reads its entry via the registered read port and the LOAD state, then shifts
// one code bit per cycle into the byte register; a completed byte waits there
// while the output register is full. A flush shifts one zero pad bit per cycle
// (8 minus the pending count when bits are pending), then sends the trailer.
// The code table's valid flags clear in the reset cycle; no clearing pass.
module huffman_code_bit_packer #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOLS      = hcbp_pkg::SYMBOLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_symbol,
  input  logic [31:0] in_code_bits,
  input  logic [5:0]  in_code_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_is_trailer,
  output logic        out_last
);

  localparam int CODE_W = (MAX_CODE_LEN < hcbp_pkg::FIELD_CODE_BITS) ?
                          MAX_CODE_LEN : hcbp_pkg::FIELD_CODE_BITS;
  localparam int LEN_W  = $clog2(CODE_W + 1);
  localparam int IW     = $clog2(CODE_W);
  localparam int AW     = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam logic [5:0] LEN_LIM = 6'(CODE_W);
  localparam logic [8:0] SYM_LIM = 9'(SYMBOLS);

  hcbp_pkg::state_t state_r, state_nxt;

  logic [6:0]        acc_r, acc_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [2:0]        tcnt_r, tcnt_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_trailer_r, out_trailer_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_xfer;
  logic              sym_ok;
  logic              out_free;
  logic              tbl_wr;
  logic [5:0]        len_sat;
  logic [CODE_W-1:0] rd_bits;
  logic [LEN_W-1:0]  rd_len;
  logic [IW-1:0]     bit_idx;
  logic              cur_bit;

  assign in_ready = (state_r == hcbp_pkg::ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign sym_ok   = ({1'b0, in_symbol} < SYM_LIM);
  assign out_free = !out_valid_r || out_ready;
  assign tbl_wr   = in_xfer && (in_kind == hcbp_pkg::KIND_LOAD) && sym_ok;
  assign len_sat  = (in_code_length > LEN_LIM) ? LEN_LIM : in_code_length;
  assign bit_idx  = IW'(rem_r - LEN_W'(1));
  assign cur_bit  = code_r[bit_idx];

  hcbp_code_table #(
    .SYMBOLS (SYMBOLS),
    .CODE_W  (CODE_W),
    .AW      (AW),
    .LEN_W   (LEN_W)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tbl_wr),
    .wr_addr (in_symbol[AW-1:0]),
    .wr_bits (in_code_bits[CODE_W-1:0]),
    .wr_len  (len_sat[LEN_W-1:0]),
    .rd_addr (in_symbol[AW-1:0]),
    .rd_bits (rd_bits),
    .rd_len  (rd_len)
  );

  always_comb begin
    state_nxt       = state_r;
    acc_nxt         = acc_r;
    cnt_nxt         = cnt_r;
    tcnt_nxt        = tcnt_r;
    code_nxt        = code_r;
    rem_nxt         = rem_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_byte_nxt    = out_byte_r;
    out_trailer_nxt = out_trailer_r;
    out_last_nxt    = out_last_r;

    case (state_r)
      hcbp_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (in_kind)
            hcbp_pkg::KIND_ENC: begin
              if (sym_ok) begin
                state_nxt = hcbp_pkg::ST_LOAD;
              end
            end
            hcbp_pkg::KIND_FLUSH: begin
              tcnt_nxt  = cnt_r;
              state_nxt = (cnt_r == 3'd0) ? hcbp_pkg::ST_TRAIL : hcbp_pkg::ST_PAD;
            end
            default: begin
            end
          endcase
        end
      end
      hcbp_pkg::ST_LOAD: begin
        code_nxt  = rd_bits;
        rem_nxt   = rd_len;
        state_nxt = (rd_len == '0) ? hcbp_pkg::ST_IDLE : hcbp_pkg::ST_SHIFT;
      end
      hcbp_pkg::ST_SHIFT: begin
        if (cnt_r != 3'd7 || out_free) begin
          acc_nxt = {acc_r[5:0], cur_bit};
          cnt_nxt = cnt_r + 3'd1;
          rem_nxt = rem_r - LEN_W'(1);
          if (cnt_r == 3'd7) begin
            out_valid_nxt   = 1'b1;
            out_byte_nxt    = {acc_r, cur_bit};
            out_trailer_nxt = 1'b0;
            out_last_nxt    = (rem_r <= LEN_W'(hcbp_pkg::BYTE_BITS));
          end
          if (rem_r == LEN_W'(1)) begin
            state_nxt = hcbp_pkg::ST_IDLE;
          end
        end
      end
      hcbp_pkg::ST_PAD: begin
        if (cnt_r != 3'd7 || out_free) begin
          acc_nxt = {acc_r[5:0], 1'b0};
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            out_valid_nxt   = 1'b1;
            out_byte_nxt    = {acc_r, 1'b0};
            out_trailer_nxt = 1'b0;
            out_last_nxt    = 1'b0;
            state_nxt       = hcbp_pkg::ST_TRAIL;
          end
        end
      end
      hcbp_pkg::ST_TRAIL: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_byte_nxt    = hcbp_pkg::TRAILER_BASE + {5'd0, tcnt_r};
          out_trailer_nxt = 1'b1;
          out_last_nxt    = 1'b1;
          acc_nxt         = '0;
          cnt_nxt         = '0;
          state_nxt       = hcbp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hcbp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hcbp_pkg::ST_IDLE;
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tcnt_r        <= tcnt_nxt;
    code_r        <= code_nxt;
    rem_r         <= rem_nxt;
    out_byte_r    <= out_byte_nxt;
    out_trailer_r <= out_trailer_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_is_trailer = out_trailer_r;
  assign out_last       = out_last_r;

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the code bit packer: table loads, symbol packing, flush trailers.
module testbench;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       trailer;
    logic       last;
  } packed_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = hcbp_pkg::KIND_LOAD;
  logic [7:0]  in_symbol = '0;
  logic [31:0] in_code_bits = '0;
  logic [5:0]  in_code_length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_is_trailer;
  logic        out_last;

  logic [31:0]  code_bits_tab [hcbp_pkg::SYMBOLS_DEF];
  logic [5:0]   code_len_tab [hcbp_pkg::SYMBOLS_DEF];
  logic [6:0]   held_bits = '0;
  int           held_count = 0;
  packed_byte_t byte_q [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  huffman_code_bit_packer u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_symbol      (in_symbol),
    .in_code_bits   (in_code_bits),
    .in_code_length (in_code_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_is_trailer (out_is_trailer),
    .out_last       (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void add_expected(input packed_byte_t item);
    byte_q.insert(byte_q.size(), item);
  endfunction

  function automatic void pack_item(input logic [1:0] kind, input logic [7:0] sym,
                                    input logic [31:0] bits, input logic [5:0] len);
    logic [63:0] acc;
    int lim;
    int clen;
    int total;
    lim = (hcbp_pkg::MAX_CODE_LEN_DEF < hcbp_pkg::FIELD_CODE_BITS) ?
          hcbp_pkg::MAX_CODE_LEN_DEF : hcbp_pkg::FIELD_CODE_BITS;
    case (kind)
      hcbp_pkg::KIND_LOAD: begin
        if (sym < hcbp_pkg::SYMBOLS_DEF) begin
          clen = (int'(len) > lim) ? lim : int'(len);
          code_len_tab[sym] = 6'(clen);
          code_bits_tab[sym] = 32'({32'd0, bits} & ((64'd1 << clen) - 64'd1));
        end
      end
      hcbp_pkg::KIND_ENC: begin
        clen = (sym < hcbp_pkg::SYMBOLS_DEF) ? int'(code_len_tab[sym]) : 0;
        if (clen != 0) begin
          acc = ({57'd0, held_bits} << clen) | {32'd0, code_bits_tab[sym]};
          total = held_count + clen;
          while (total >= hcbp_pkg::BYTE_BITS) begin
            total -= hcbp_pkg::BYTE_BITS;
            add_expected('{data: 8'(acc >> total), trailer: 1'b0,
                           last: (total < hcbp_pkg::BYTE_BITS)});
          end
          held_bits = 7'(acc & ((64'd1 << total) - 64'd1));
          held_count = total;
        end
      end
      hcbp_pkg::KIND_FLUSH: begin
        if (held_count != 0)
          add_expected('{data: 8'({1'b0, held_bits} << (hcbp_pkg::BYTE_BITS - held_count)),
                         trailer: 1'b0, last: 1'b0});
        add_expected('{data: hcbp_pkg::TRAILER_BASE + 8'(held_count), trailer: 1'b1,
                       last: 1'b1});
        held_bits = '0;
        held_count = 0;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void note_mismatch(input string what, input packed_byte_t want,
                                        input packed_byte_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t %s: expected byte %02h trailer %0b last %0b, %s %02h trailer %0b last %0b",
               $time, what, want.data, want.trailer, want.last, "got byte",
               got.data, got.trailer, got.last);
  endfunction

  task automatic send_item(input logic [1:0] kind, input logic [7:0] sym,
                           input logic [31:0] bits, input logic [5:0] len);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_symbol      <= sym;
    in_code_bits   <= bits;
    in_code_length <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pack_item(kind, sym, bits, len);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (byte_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    packed_byte_t want;
    packed_byte_t got;
    if (rst_n) begin
      got = '{data: out_byte, trailer: out_is_trailer, last: out_last};
      if (out_valid && out_ready) begin
        if (byte_q.size() == 0) begin
          note_mismatch("unexpected transfer", '0, got);
        end else begin
          want = byte_q.pop_front();
          if (got.data !== want.data || got.trailer !== want.trailer || got.last !== want.last)
            note_mismatch("wrong result", want, got);
        end
      end
      if ((out_valid && out_ready) || (in_valid && in_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    send_item(hcbp_pkg::KIND_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd32);
    send_item(hcbp_pkg::KIND_LOAD, 8'd255, 32'h0000_0000, 6'd1);
    send_item(hcbp_pkg::KIND_LOAD, 8'd7, 32'hFFFF_FFFF, 6'd63);
    send_item(hcbp_pkg::KIND_LOAD, 8'd8, 32'hFFFF_FFF5, 6'd4);
    send_item(hcbp_pkg::KIND_LOAD, 8'd9, 32'hA5A5_A5A5, 6'd0);
    send_item(hcbp_pkg::KIND_LOAD, 8'd10, 32'h1234_5678, 6'd33);
    send_item(hcbp_pkg::KIND_LOAD, 8'd11, 32'hFFFF_FF7F, 6'd7);
    send_item(hcbp_pkg::KIND_ENC, 8'd9, 32'h0, 6'd0);
    send_item(hcbp_pkg::KIND_ENC, 8'd200, 32'h0, 6'd0);
    send_item(hcbp_pkg::KIND_ENC, 8'd255, 32'h0, 6'd0);
    send_item(hcbp_pkg::KIND_ENC, 8'd8, 32'h0, 6'd0);
    send_item(hcbp_pkg::KIND_FLUSH, 8'd0, 32'h0, 6'd0);
    send_item(hcbp_pkg::KIND_FLUSH, 8'd0, 32'h0, 6'd0);
    send_item(hcbp_pkg::KIND_ENC, 8'd0, 32'h0, 6'd0);
    send_item(hcbp_pkg::KIND_ENC, 8'd255, 32'h0, 6'd0);
    send_item(hcbp_pkg::KIND_ENC, 8'd7, 32'h0, 6'd0);
    send_item(hcbp_pkg::KIND_ENC, 8'd8, 32'h0, 6'd0);
    send_item(hcbp_pkg::KIND_ENC, 8'd10, 32'h0, 6'd0);
    send_item(hcbp_pkg::KIND_FLUSH, 8'd0, 32'h0, 6'd0);
    send_item(hcbp_pkg::KIND_ENC, 8'd11, 32'h0, 6'd0);
    send_item(hcbp_pkg::KIND_ENC, 8'd0, 32'h0, 6'd0);
    send_item(KIND_NONE, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    send_item(hcbp_pkg::KIND_FLUSH, 8'd0, 32'h0, 6'd0);
    hold_until_drained();
  endtask

  task automatic test_random_stream(input int idle, input int stall, input int count);
    logic [1:0]  kind;
    logic [7:0]  sym;
    logic [31:0] bits;
    logic [5:0]  len;
    int          pick;
    int          r;
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      sym  = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(15));
      bits = $urandom;
      len  = 6'($urandom);
      if (pick < 20) begin
        kind = hcbp_pkg::KIND_LOAD;
        r = $urandom_range(19);
        if (r == 0)
          len = 6'd0;
        else if (r == 1)
          len = 6'($urandom_range(63, 33));
        else
          len = 6'($urandom_range(32, 1));
      end else if (pick < 85) begin
        kind = hcbp_pkg::KIND_ENC;
      end else if (pick < 96) begin
        kind = hcbp_pkg::KIND_FLUSH;
      end else begin
        kind = KIND_NONE;
      end
      send_item(kind, sym, bits, len);
    end
    hold_until_drained();
  endtask

  initial begin
    foreach (code_len_tab[i]) begin
      code_len_tab[i]  = '0;
      code_bits_tab[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_stream(0, 0, 32);
    test_random_stream(81, 0, 32);
    test_random_stream(0, 81, 32);
    test_random_stream(6, 6, 31);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (byte_q.size() != 0) begin
      mismatches += byte_q.size();
      $display("%0d expected results never arrived", byte_q.size());
    end
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
